// ===== hw/rtl/utv_pkg.sv =====
// ---------------------------------------------------------------------------
// UTF-8 text validator package
// Shared types, verdict codes and the lead byte decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package utv_pkg;

  // Verdict codes as they leave the block.
  typedef enum logic [2:0] {
    VERDICT_VALID     = 3'd0,
    VERDICT_BAD_LEAD  = 3'd1,
    VERDICT_BAD_CONT  = 3'd2,
    VERDICT_TRUNCATED = 3'd3,
    VERDICT_ALL_ASCII = 3'd4
  } verdict_t;

  // Held error codes; they share their values with the verdict codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_LEAD  = 2'd1;
  localparam logic [1:0] ERR_BAD_CONT  = 2'd2;

  // Continuation count that marks an illegal lead byte.
  localparam logic [2:0] LEAD_ILLEGAL  = 3'd7;

  // Running state of one text.
  typedef struct packed {
    logic [2:0] pending;     // continuation bytes still expected
    logic       ascii_only;  // every byte so far was below 0x80
    logic [1:0] err;         // first error seen, sticky
  } utv_state_t;

  localparam utv_state_t STATE_CLEAR = '{pending: 3'd0, ascii_only: 1'b1, err: ERR_NONE};

  // Number of continuation bytes that follow a lead byte at or above 0x80.
  function automatic logic [2:0] lead_extra(input logic [7:0] b);
    logic [2:0] n;
    begin
      if (b >= 8'hFE)      n = LEAD_ILLEGAL;
      else if (b >= 8'hFC) n = 3'd5;
      else if (b >= 8'hF8) n = 3'd4;
      else if (b >= 8'hF0) n = 3'd3;
      else if (b >= 8'hE0) n = 3'd2;
      else if (b >= 8'hC0) n = 3'd1;
      else                 n = LEAD_ILLEGAL;
      return n;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utv_byte_check.sv =====
// ---------------------------------------------------------------------------
// UTF-8 byte checker
// Combinational state update for one byte and the verdict on a last byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utv_byte_check (
  input  wire utv_pkg::utv_state_t state,
  input  wire logic [7:0]          text_byte,
  input  wire logic                last_byte,
  output utv_pkg::utv_state_t      state_next,
  output logic                     is_utf8,
  output utv_pkg::verdict_t        verdict_code
);
  import utv_pkg::*;

  utv_state_t upd;
  logic [2:0] n;

  assign n = lead_extra(text_byte);

  always_comb begin
    upd = state;
    if (state.err == ERR_NONE) begin
      if (text_byte[7]) begin
        upd.ascii_only = 1'b0;
      end
      if (state.pending == 3'd0) begin
        if (text_byte[7]) begin
          if (n == LEAD_ILLEGAL) begin
            upd.err = ERR_BAD_LEAD;
          end else begin
            upd.pending = n;
          end
        end
      end else if (text_byte[7:6] != 2'b10) begin
        upd.err = ERR_BAD_CONT;
      end else begin
        upd.pending = state.pending - 3'd1;
      end
    end
  end

  // A held error wins, then an open sequence, then an all-ASCII text.
  always_comb begin
    if (upd.err != ERR_NONE) begin
      verdict_code = verdict_t'({1'b0, upd.err});
    end else if (upd.pending != 3'd0) begin
      verdict_code = VERDICT_TRUNCATED;
    end else if (upd.ascii_only) begin
      verdict_code = VERDICT_ALL_ASCII;
    end else begin
      verdict_code = VERDICT_VALID;
    end
  end

  assign is_utf8    = (verdict_code == VERDICT_VALID);
  assign state_next = last_byte ? STATE_CLEAR : upd;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_text_validator_unit.sv =====
// ---------------------------------------------------------------------------
// UTF-8 text validator unit
// Checks a byte stream against six-byte UTF-8 and gives one verdict per text.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one text byte per transfer,
//   with last_byte set on the final byte of a text. The output channel
//   (out_valid/out_ready) carries one verdict per text: is_utf8 and
//   verdict_code (valid, bad lead, bad continuation, truncated, all ASCII).
//   Bytes that are not last give no output transfer.
//   A byte taken at a clock edge lands in an input register and is checked
//   against the running state; on a last byte its verdict is loaded into
//   the result register, which drives out_valid. One byte per cycle is
//   sustained while no last byte waits for the result register; the state
//   update steps through a single byte at a time.
//   While a verdict waits in the result register, further bytes that are not
//   last keep flowing; only a last byte waits in the input register until
//   the result register is free, and then in_ready drops.
//   Synchronous reset empties both registers and returns the text state to
//   its initial value (no pending continuations, all ASCII, no error).
//   After each verdict the text state clears for the next text.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_validator_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            is_utf8,
  output logic [2:0]      verdict_code
);
  import utv_pkg::*;

  // Input register.
  logic       in_full;
  logic [7:0] byte_q;
  logic       last_q;

  // Running text state.
  utv_state_t state;
  utv_state_t state_next;

  // Checker results for the byte in the input register.
  logic     chk_is_utf8;
  verdict_t chk_verdict;

  logic step;

  // A byte that is not last never needs the result register, so it always
  // proceeds; a last byte proceeds once the result register can take it.
  assign step     = in_full && (!last_q || !out_valid || out_ready);
  assign in_ready = !in_full || step;

  utv_byte_check u_check (
    .state        (state),
    .text_byte    (byte_q),
    .last_byte    (last_q),
    .state_next   (state_next),
    .is_utf8      (chk_is_utf8),
    .verdict_code (chk_verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= text_byte;
      last_q <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && last_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_q) begin
      is_utf8      <= chk_is_utf8;
      verdict_code <= chk_verdict;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// UTF-8 text validator testbench
// Streams directed and random texts through the validator byte by byte. The
// bytes are tracked against a six-byte UTF-8 checker kept in the bench, and
// every verdict transfer is compared with the oldest predicted verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import utv_pkg::*;

  // Cycles without any transfer before the run is declared hung. A correct
  // run never gets near this, even under the heaviest random stalls.
  localparam int STALL_LIMIT = 5000;
  // Least number of random text bytes queued per phase.
  localparam int PHASE_BYTES = 135;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } text_item_t;

  typedef struct {
    logic     is_utf8;
    verdict_t code;
  } verdict_exp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_utf8;
  logic [2:0] verdict_code;

  // Bytes waiting to be driven, and verdicts waiting to be seen.
  text_item_t   byte_feed [$];
  verdict_exp_t verdict_queue [$];
  text_item_t   next_item;
  verdict_exp_t oldest_verdict;
  int           queued_bytes = 0;
  int           fail_count = 0;
  int           stall_cycles = 0;

  // Percentages of cycles in which each side holds off.
  int send_idle_pct = 24;
  int recv_idle_pct = 64;

  // Bench copy of the text state.
  logic [2:0] open_conts = 3'd0;
  logic       only_ascii = 1'b1;
  logic [1:0] first_err  = ERR_NONE;

  utf8_text_validator_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_utf8      (is_utf8),
    .verdict_code (verdict_code)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Number of continuation bytes announced by a byte with its top bit set.
  // Stray continuations and the 0xFE/0xFF bytes decode as illegal leads.
  function automatic logic [2:0] conts_after_lead(input logic [7:0] b);
    logic [2:0] n;
    casez (b)
      8'b1111_111?: n = LEAD_ILLEGAL;
      8'b1111_110?: n = 3'd5;
      8'b1111_10??: n = 3'd4;
      8'b1111_0???: n = 3'd3;
      8'b1110_????: n = 3'd2;
      8'b110?_????: n = 3'd1;
      default:      n = LEAD_ILLEGAL;
    endcase
    return n;
  endfunction

  // Advances the text state by one accepted byte. On the last byte of a text
  // the verdict is queued and the state clears for the next text.
  task automatic track_text_byte(input logic [7:0] b, input logic is_last);
    logic [2:0]   n;
    verdict_exp_t v;
    // Once an error is held, the rest of the text only matters for its end.
    if (first_err == ERR_NONE) begin
      if (b[7]) only_ascii = 1'b0;
      if (open_conts == 3'd0) begin
        if (b[7]) begin
          n = conts_after_lead(b);
          if (n == LEAD_ILLEGAL) first_err = ERR_BAD_LEAD;
          else open_conts = n;
        end
      end else if (b[7:6] != 2'b10) begin
        first_err = ERR_BAD_CONT;
      end else begin
        open_conts = open_conts - 3'd1;
      end
    end
    if (is_last) begin
      // A held error wins over truncation, which wins over all ASCII.
      if (first_err == ERR_BAD_LEAD) v.code = VERDICT_BAD_LEAD;
      else if (first_err == ERR_BAD_CONT) v.code = VERDICT_BAD_CONT;
      else if (open_conts != 3'd0) v.code = VERDICT_TRUNCATED;
      else if (only_ascii) v.code = VERDICT_ALL_ASCII;
      else v.code = VERDICT_VALID;
      v.is_utf8 = (v.code == VERDICT_VALID);
      verdict_queue.insert(verdict_queue.size(), v);
      open_conts = 3'd0;
      only_ascii = 1'b1;
      first_err  = ERR_NONE;
    end
  endtask

  // Queues one text, marking its final byte as last.
  task automatic push_text(input logic [7:0] txt [$]);
    text_item_t item;
    for (int i = 0; i < txt.size(); i++) begin
      item.value   = txt[i];
      item.is_last = (i == txt.size() - 1);
      byte_feed.insert(byte_feed.size(), item);
    end
    queued_bytes += txt.size();
  endtask

  // Builds one random text. Most texts are well-formed sequences with random
  // payload bits; the rest are pure ASCII, raw noise, texts with one byte
  // overwritten, and texts cut off part way.
  task automatic add_random_text();
    logic [7:0] txt [$];
    int         kind;
    int         len;
    int         pos;
    kind = $urandom_range(99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) txt.insert(txt.size(), 8'($urandom_range(0, 127)));
    end else if (kind < 20) begin
      repeat ($urandom_range(1, 6)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(0, 5);
        case (len)
          0: txt.insert(txt.size(), {1'b0, 7'($urandom)});
          1: txt.insert(txt.size(), {3'b110, 5'($urandom)});
          2: txt.insert(txt.size(), {4'b1110, 4'($urandom)});
          3: txt.insert(txt.size(), {5'b11110, 3'($urandom)});
          4: txt.insert(txt.size(), {6'b111110, 2'($urandom)});
          default: txt.insert(txt.size(), {7'b1111110, 1'($urandom)});
        endcase
        repeat (len) txt.insert(txt.size(), {2'b10, 6'($urandom)});
      end
      if (kind < 30) begin
        pos = $urandom_range(0, txt.size() - 1);
        txt[pos] = 8'($urandom_range(0, 255));
      end else if (kind < 38 && txt.size() > 1) begin
        repeat ($urandom_range(1, txt.size() - 1)) void'(txt.pop_back());
      end
    end
    push_text(txt);
  endtask

  task automatic fill_random_phase();
    int target;
    target = queued_bytes + PHASE_BYTES;
    while (queued_bytes < target) add_random_text();
  endtask

  // Driver: a new byte is offered only when the previous one has been taken
  // or none is on the bus, so valid and the payload hold until the transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = byte_feed.pop_front();
        in_valid  <= 1'b1;
        text_byte <= next_item.value;
        last_byte <= next_item.is_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: the verdict side is checked before the byte side is tracked, so
  // a verdict can never be matched against a text that ends at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdict_queue.size() == 0) begin
          $error("verdict transfer with none expected: is_utf8=%0b verdict_code=%0d",
                 is_utf8, verdict_code);
          fail_count++;
        end else begin
          oldest_verdict = verdict_queue.pop_front();
          if (is_utf8 !== oldest_verdict.is_utf8) begin
            $error("is_utf8 mismatch: expected %0b, actual %0b",
                   oldest_verdict.is_utf8, is_utf8);
            fail_count++;
          end
          if (verdict_code !== oldest_verdict.code) begin
            $error("verdict_code mismatch: expected %0d, actual %0d",
                   oldest_verdict.code, verdict_code);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) track_text_byte(text_byte, last_byte);
    end
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [7:0] txt [$];

    // Directed texts: single ASCII extremes, the smallest and largest lead
    // of the two-byte form, a full six-byte sequence, the two illegal lead
    // bytes, a stray continuation, a bad continuation followed by ignored
    // bytes, a truncated sequence, and ASCII mixed with a three-byte form.
    txt = '{8'h00};                                     push_text(txt);
    txt = '{8'h7F};                                     push_text(txt);
    txt = '{8'hC0, 8'h80};                              push_text(txt);
    txt = '{8'hDF, 8'hBF};                              push_text(txt);
    txt = '{8'hFD, 8'hBF, 8'h80, 8'h80, 8'h80, 8'hBF};  push_text(txt);
    txt = '{8'hFE};                                     push_text(txt);
    txt = '{8'hFF};                                     push_text(txt);
    txt = '{8'h80};                                     push_text(txt);
    txt = '{8'hE0, 8'h41, 8'hFF};                       push_text(txt);
    txt = '{8'hF8, 8'h80, 8'h80};                       push_text(txt);
    txt = '{8'h41, 8'hEF, 8'hBF, 8'hBF};                push_text(txt);

    // First phase: sender idles now and then, receiver idles often.
    fill_random_phase();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (byte_feed.size() != 0) @(posedge clk);

    // Second phase: the other way round.
    send_idle_pct = 64;
    recv_idle_pct = 24;
    fill_random_phase();
    while (byte_feed.size() != 0) @(posedge clk);

    // Third phase: both sides run flat out.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random_phase();

    // Wait until the last byte is taken and every verdict has come out,
    // then keep clocking the block so that any stray verdict would show.
    while (byte_feed.size() != 0 || in_valid) @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
